### rtl/dcs_pkg.sv
// ----------------------------------------------------------------------------
// dcs_pkg
// Shared widths, types and the controller/datapath command and status groups
// of the difference constraint solver.
// ----------------------------------------------------------------------------
package dcs_pkg;

  localparam int MAX_VARS  = 32;
  localparam int MAX_CONS  = 256;
  localparam int DIFF_W    = 16;
  localparam int VAR_W     = $clog2(MAX_VARS);
  localparam int CNT_W     = 6;
  localparam int ADDR_W    = $clog2(MAX_CONS);
  localparam int SCOUNT_W  = ADDR_W + 1;
  localparam int OUT_W     = 20;
  // Working values may grow well past the reported range while a positive
  // cycle is being chased, so they are kept wider than the result field.
  localparam int VAL_W     = 30;
  localparam logic [OUT_W-1:0] VALUE_MAX = {OUT_W{1'b1}};

  typedef struct packed {
    logic [VAR_W-1:0]        target;
    logic [VAR_W-1:0]        source;
    logic signed [DIFF_W-1:0] diff;
  } dcs_entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_PASS,
    S_READ,
    S_EVAL,
    S_FAIL,
    S_EMIT,
    S_LOAD,
    S_HOLD
  } dcs_state_t;

  typedef struct packed {
    logic take;
    logic solve_init;
    logic next_pass;
    logic cons_rd;
    logic skip;
    logic val_rd;
    logic relax;
    logic out_rd;
    logic out_load;
    logic out_fail;
    logic out_next;
    logic finish;
  } dcs_cmd_t;

  typedef struct packed {
    logic cons_done;
    logic changed;
    logic pass_last;
    logic idx_bad;
    logic held_last;
  } dcs_sts_t;

endpackage

### rtl/dcs_if.sv
// ----------------------------------------------------------------------------
// dcs_if
// Channel interfaces of the difference constraint solver: constraint input,
// result output and the configuration write channel.
// ----------------------------------------------------------------------------
interface dcs_in_if;
  logic                                valid;
  logic                                ready;
  logic [dcs_pkg::VAR_W-1:0]           target_var;
  logic [dcs_pkg::VAR_W-1:0]           source_var;
  logic signed [dcs_pkg::DIFF_W-1:0]   min_diff;
  logic                                last_constraint;

  modport source (output valid, target_var, source_var, min_diff, last_constraint,
                  input ready);
  modport sink (input valid, target_var, source_var, min_diff, last_constraint,
                output ready);
endinterface

interface dcs_out_if;
  logic                          valid;
  logic                          ready;
  logic [dcs_pkg::VAR_W-1:0]     var_index;
  logic [dcs_pkg::OUT_W-1:0]     min_value;
  logic                          solvable;
  logic                          dropped;
  logic                          last_result;

  modport source (output valid, var_index, min_value, solvable, dropped, last_result,
                  input ready);
  modport sink (input valid, var_index, min_value, solvable, dropped, last_result,
                output ready);
endinterface

interface dcs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dcs_pkg::CNT_W-1:0]     data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### rtl/dcs_ctrl.sv
// ----------------------------------------------------------------------------
// dcs_ctrl
// Sequencer for loading, relaxation passes and result delivery.
// ----------------------------------------------------------------------------
module dcs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  dcs_pkg::dcs_sts_t sts,
  output dcs_pkg::dcs_cmd_t cmd
);
  import dcs_pkg::*;

  dcs_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_last) begin
            state_next = S_START;
          end
        end
      end
      S_START: begin
        cmd.solve_init = 1'b1;
        state_next     = S_PASS;
      end
      S_PASS: begin
        if (sts.cons_done) begin
          if (!sts.changed) begin
            state_next = S_EMIT;
          end else if (sts.pass_last) begin
            state_next = S_FAIL;
          end else begin
            cmd.next_pass = 1'b1;
          end
        end else begin
          cmd.cons_rd = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        if (sts.idx_bad) begin
          cmd.skip   = 1'b1;
          state_next = S_PASS;
        end else begin
          cmd.val_rd = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.relax  = 1'b1;
        state_next = S_PASS;
      end
      S_FAIL: begin
        cmd.out_fail = 1'b1;
        state_next   = S_HOLD;
      end
      S_EMIT: begin
        cmd.out_rd = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.out_load = 1'b1;
        state_next   = S_HOLD;
      end
      S_HOLD: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.held_last) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.out_next = 1'b1;
            state_next   = S_EMIT;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_last_starts_solve: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && in_last) |=> state == S_START)
    else $error("final constraint did not start a solve");

  a_fail_on_last_pass: assert property (@(posedge clk) disable iff (rst)
    (state == S_PASS && sts.cons_done && sts.changed && sts.pass_last)
    |=> state == S_FAIL)
    else $error("change in final pass did not flag an unsolvable system");

  a_hold_until_taken: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD && !out_ready) |=> state == S_HOLD)
    else $error("result left before it was taken");

endmodule

### rtl/dcs_datapath.sv
// ----------------------------------------------------------------------------
// dcs_datapath
// Constraint store, value table, pass and index counters, relaxation unit and
// result register.
// ----------------------------------------------------------------------------
module dcs_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [dcs_pkg::CNT_W-1:0]         cfg_data,
  input  logic [dcs_pkg::VAR_W-1:0]         in_target,
  input  logic [dcs_pkg::VAR_W-1:0]         in_source,
  input  logic signed [dcs_pkg::DIFF_W-1:0] in_diff,
  input  dcs_pkg::dcs_cmd_t                 cmd,
  output dcs_pkg::dcs_sts_t                 sts,
  output logic [dcs_pkg::VAR_W-1:0]         out_index,
  output logic [dcs_pkg::OUT_W-1:0]         out_value,
  output logic                              out_solvable,
  output logic                              out_dropped,
  output logic                              out_last
);
  import dcs_pkg::*;

  logic [CNT_W-1:0]    variable_count;
  logic [CNT_W-1:0]    n_act;
  logic [SCOUNT_W-1:0] stored_count;
  logic [SCOUNT_W-1:0] cons_idx;
  logic [CNT_W-1:0]    pass_counter;
  logic [VAR_W-1:0]    var_idx;
  logic                drop_flag;
  logic                changed_flag;

  dcs_entry_t          cons_mem [MAX_CONS];
  dcs_entry_t          cons_q;
  logic [VAL_W-1:0]    val_mem [MAX_VARS];
  logic [MAX_VARS-1:0] val_ok;
  logic [VAL_W-1:0]    val_s_q;
  logic [VAL_W-1:0]    val_t_q;

  logic                in_bad;
  logic                store_full;
  logic [VAR_W-1:0]    rd_a;
  logic signed [VAL_W:0] cand;
  logic                improve;

  // Out-of-range register values are folded into 1..MAX_VARS.
  always_comb begin
    if (variable_count == '0) begin
      n_act = CNT_W'(1);
    end else if (variable_count > CNT_W'(MAX_VARS)) begin
      n_act = CNT_W'(MAX_VARS);
    end else begin
      n_act = variable_count;
    end
  end

  assign in_bad     = (CNT_W'(in_target) >= n_act) || (CNT_W'(in_source) >= n_act);
  assign store_full = (stored_count == SCOUNT_W'(MAX_CONS));
  assign rd_a       = cmd.out_rd ? var_idx : cons_q.source;

  assign cand    = $signed({1'b0, val_s_q})
                 + $signed({{(VAL_W + 1 - DIFF_W){cons_q.diff[DIFF_W-1]}}, cons_q.diff});
  assign improve = cand > $signed({1'b0, val_t_q});

  // Constraint store: one write, one registered read.
  always_ff @(posedge clk) begin
    if (cmd.take && !in_bad && !store_full) begin
      cons_mem[stored_count[ADDR_W-1:0]] <= '{target: in_target, source: in_source,
                                             diff: in_diff};
    end
    if (cmd.cons_rd) begin
      cons_q <= cons_mem[cons_idx[ADDR_W-1:0]];
    end
  end

  // Value table: one write, two registered reads. An entry not yet written in
  // this solve reads as zero.
  always_ff @(posedge clk) begin
    if (cmd.relax && improve) begin
      val_mem[cons_q.target] <= cand[VAL_W-1:0];
    end
    if (cmd.val_rd || cmd.out_rd) begin
      val_s_q <= val_ok[rd_a] ? val_mem[rd_a] : '0;
      val_t_q <= val_ok[cons_q.target] ? val_mem[cons_q.target] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.solve_init) begin
      val_ok <= '0;
    end else if (cmd.relax && improve) begin
      val_ok[cons_q.target] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      variable_count <= CNT_W'(MAX_VARS);
      stored_count   <= '0;
      cons_idx       <= '0;
      pass_counter   <= '0;
      var_idx        <= '0;
      drop_flag      <= 1'b0;
      changed_flag   <= 1'b0;
    end else begin
      if (cfg_we) begin
        variable_count <= cfg_data;
      end
      if (cmd.take) begin
        if (in_bad || store_full) begin
          drop_flag <= 1'b1;
        end else begin
          stored_count <= stored_count + SCOUNT_W'(1);
        end
      end
      if (cmd.solve_init) begin
        cons_idx     <= '0;
        pass_counter <= '0;
        changed_flag <= 1'b0;
        var_idx      <= '0;
      end
      if (cmd.next_pass) begin
        cons_idx     <= '0;
        pass_counter <= pass_counter + CNT_W'(1);
        changed_flag <= 1'b0;
      end
      if (cmd.skip) begin
        drop_flag <= 1'b1;
        cons_idx  <= cons_idx + SCOUNT_W'(1);
      end
      if (cmd.relax) begin
        if (improve) begin
          changed_flag <= 1'b1;
        end
        cons_idx <= cons_idx + SCOUNT_W'(1);
      end
      if (cmd.out_next) begin
        var_idx <= var_idx + VAR_W'(1);
      end
      if (cmd.finish) begin
        stored_count <= '0;
        drop_flag    <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_index    <= var_idx;
      out_value    <= (val_s_q > VAL_W'(VALUE_MAX)) ? VALUE_MAX : val_s_q[OUT_W-1:0];
      out_solvable <= 1'b1;
      out_dropped  <= drop_flag;
      out_last     <= (CNT_W'(var_idx) == n_act - CNT_W'(1));
    end else if (cmd.out_fail) begin
      out_index    <= '0;
      out_value    <= '0;
      out_solvable <= 1'b0;
      out_dropped  <= drop_flag;
      out_last     <= 1'b1;
    end
  end

  assign sts.cons_done = (cons_idx == stored_count);
  assign sts.changed   = changed_flag;
  assign sts.pass_last = (pass_counter == n_act - CNT_W'(1));
  assign sts.idx_bad   = (CNT_W'(cons_q.target) >= n_act) || (CNT_W'(cons_q.source) >= n_act);
  assign sts.held_last = out_last;

  a_finish_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (stored_count == '0 && !drop_flag))
    else $error("store or drop flag not cleared after a solve");

  a_raise_marks_change: assert property (@(posedge clk) disable iff (rst)
    (cmd.relax && improve) |=> changed_flag)
    else $error("raised value not recorded as a change");

  a_pass_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.next_pass |=> (cons_idx == '0 && !changed_flag))
    else $error("new pass did not restart at the first constraint");

endmodule

### rtl/difference_constraint_solver_core.sv
// ----------------------------------------------------------------------------
// difference_constraint_solver_core
// Loads difference constraints x[target] - x[source] >= min_diff and solves
// them by Bellman-Ford relaxation. A constraint without the last mark is
// taken on its handshake. The marked one starts a solve: each pass reads
// every stored constraint from the store, then its source and target values
// from the value table, then relaxes it (a constraint that names a variable
// outside the current count is skipped before the value read), and up to
// variable_count passes run (the count folded into 1..MAX_VARS), ending
// early after a pass with no change. Results then follow, each read, loaded
// and held until the sink takes it: one per variable in index order, or a
// single result with solvable low when a positive cycle exists. No new
// constraint is taken until the last result of a solve has been delivered.
// The variable count may be written at any time the block is idle.
// ----------------------------------------------------------------------------
module difference_constraint_solver_core (
  input logic      clk,
  input logic      rst,
  dcs_in_if.sink   cons,
  dcs_out_if.source result,
  dcs_cfg_if.sink  cfg
);
  import dcs_pkg::*;

  dcs_cmd_t cmd;
  dcs_sts_t sts;

  assign cfg.ready = 1'b1;

  dcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cons.valid),
    .in_last   (cons.last_constraint),
    .in_ready  (cons.ready),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  dcs_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg.valid),
    .cfg_data     (cfg.data),
    .in_target    (cons.target_var),
    .in_source    (cons.source_var),
    .in_diff      (cons.min_diff),
    .cmd          (cmd),
    .sts          (sts),
    .out_index    (result.var_index),
    .out_value    (result.min_value),
    .out_solvable (result.solvable),
    .out_dropped  (result.dropped),
    .out_last     (result.last_result)
  );

endmodule
